FILE: hdl/hbc_pkg.sv
`default_nettype none
package hbc_pkg;

  localparam int NUM_ENTRIES = 32;
  localparam int NUM_BUCKETS = 13;

  // Fixed field widths
  localparam int DEV_W  = 8;
  localparam int BLK_W  = 32;
  localparam int IDX_W  = 5;
  localparam int TICK_W = 32;
  localparam int RCNT_W = 8;
  localparam int BKT_W  = 4;

  // Derived sizes
  localparam int ENT_W   = $clog2(NUM_ENTRIES);
  localparam int USED_W  = $clog2(NUM_ENTRIES + 1);
  localparam int NIB_CNT = BLK_W / 4;
  localparam int NIB_W   = $clog2(NIB_CNT);

  localparam logic [RCNT_W-1:0] RCNT_MAX = '1;

  typedef enum logic [1:0] {
    MODE_GET     = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_PIN     = 2'd2,
    MODE_UNPIN   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_ZERO    = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_ALLOC,
    S_OPRD,
    S_DONE
  } state_e;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [RCNT_W-1:0] cnt;
    logic [TICK_W-1:0] rtime;
    logic              vld;
    logic [BKT_W-1:0]  home;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Hash unit handshake toward the controller
  typedef struct packed {
    logic             done;
    logic [BKT_W-1:0] home;
  } hash_rsp_t;

  // One remainder step: (r * 16 + nib) mod NUM_BUCKETS, r already reduced
  function automatic logic [BKT_W-1:0] bkt_step(logic [BKT_W-1:0] r, logic [3:0] nib);
    logic [BKT_W+4:0] v;
    logic [BKT_W+4:0] m;
    v = {1'b0, r, nib};
    for (int s = 4; s >= 0; s--) begin
      m = (BKT_W + 5)'(NUM_BUCKETS) << s;
      if (v >= m) begin
        v = v - m;
      end
    end
    return v[BKT_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: hdl/hbc_if.sv
`default_nettype none
interface hbc_req_if import hbc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [1:0]         mode;
  logic [DEV_W-1:0]   device;
  logic [BLK_W-1:0]   block_number;
  logic [IDX_W-1:0]   entry_index;
  logic [TICK_W-1:0]  now_tick;

  modport source (output valid, mode, device, block_number, entry_index, now_tick,
                  input ready);
  modport sink   (input valid, mode, device, block_number, entry_index, now_tick,
                  output ready);
endinterface

interface hbc_rsp_if import hbc_pkg::*;;
  logic               valid;
  logic               ready;
  logic [IDX_W-1:0]   result_entry;
  logic [1:0]         status;
  logic               was_hit;
  logic               needs_fill;

  modport source (output valid, result_entry, status, was_hit, needs_fill, input ready);
  modport sink   (input valid, result_entry, status, was_hit, needs_fill, output ready);
endinterface
`default_nettype wire

FILE: hdl/hbc_ram.sv
`default_nettype none
module hbc_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Single write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

FILE: hdl/hbc_hash.sv
`default_nettype none
module hbc_hash import hbc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [BLK_W-1:0] blk_i,
  output hash_rsp_t             rsp_o
);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [NIB_W-1:0] cnt_q, cnt_d;
  logic [BLK_W-1:0] sh_q, sh_d;
  logic [BKT_W-1:0] rem_q, rem_d;

  // Block number mod bucket count, one nibble per cycle, MSB first
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = blk_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = bkt_step(rem_q, sh_q[BLK_W-1 -: 4]);
      sh_d  = sh_q << 4;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == NIB_W'(NIB_CNT - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.home = rem_q;

endmodule
`default_nettype wire

FILE: hdl/hashed_block_buffer_cache_core.sv
// Get: hash the block number, scan over NUM_ENTRIES RAM reads, allocate, load the
//   response; a hit ends the scan early. Release/pin/unpin: read, update, respond.
// Flow: one transaction at a time; the next request is taken as the response appears,
//   and the scan sets the get rate.
// Reset: asynchronous, active low; clears the control state and the used-entry
//   count. Entry RAM contents are not cleared and are only used once handed out.
`default_nettype none
module hashed_block_buffer_cache_core import hbc_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hbc_req_if.sink    req_i,
  hbc_rsp_if.source  rsp_o
);

  state_e            state_q, state_d;
  logic [USED_W-1:0] used_q, used_d;

  // Latched transaction
  mode_e             mode_q, mode_d;
  logic [DEV_W-1:0]  dev_q, dev_d;
  logic [BLK_W-1:0]  blk_q, blk_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [TICK_W-1:0] now_q, now_d;
  logic [BKT_W-1:0]  home_q, home_d;

  // Scan bookkeeping
  logic [ENT_W:0]    addr_q, addr_d;
  logic              rd_vld_q, rd_vld_d;
  logic [ENT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              cand_q, cand_d;
  logic [ENT_W-1:0]  cand_idx_q, cand_idx_d;
  logic [BKT_W-1:0]  cand_dist_q, cand_dist_d;
  logic [TICK_W-1:0] cand_time_q, cand_time_d;

  // Result and output stage
  logic [IDX_W-1:0]  res_entry_q, res_entry_d;
  status_e           res_stat_q, res_stat_d;
  logic              res_hit_q, res_hit_d;
  logic              res_fill_q, res_fill_d;
  logic              rsp_vld_q, rsp_vld_d;
  logic [IDX_W-1:0]  rsp_entry_q, rsp_entry_d;
  status_e           rsp_stat_q, rsp_stat_d;
  logic              rsp_hit_q, rsp_hit_d;
  logic              rsp_fill_q, rsp_fill_d;

  // RAM port signals
  logic              ram_we, ram_re;
  logic [ENT_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;
  logic [ENT_W*0+ENTRY_W-1:0] ram_rdata_raw;

  logic              hash_start;
  hash_rsp_t         hash_rsp;

  // Helpers for the scan and the read-modify-write path
  logic              live;
  logic              scan_live;
  logic [BKT_W:0]    dist_ext;
  logic [BKT_W-1:0]  gap;
  logic              req_acc;

  hbc_ram #(
    .Width (ENTRY_W),
    .Depth (NUM_ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = entry_t'(ram_rdata_raw);

  hbc_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .blk_i   (blk_d),
    .rsp_o   (hash_rsp)
  );

  assign req_i.ready = (state_q == S_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;

  assign live      = 32'(idx_q) < 32'(used_q);
  assign scan_live = 32'(rd_idx_q) < 32'(used_q);

  // Bucket distance from home, with wrap
  always_comb begin
    if (ram_rdata.home >= home_q) begin
      dist_ext = {1'b0, ram_rdata.home} - {1'b0, home_q};
    end else begin
      dist_ext = {1'b0, ram_rdata.home} + (BKT_W + 1)'(NUM_BUCKETS) - {1'b0, home_q};
    end
    gap = dist_ext[BKT_W-1:0];
  end

  // Next state and datapath control
  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    mode_d      = mode_q;
    dev_d       = dev_q;
    blk_d       = blk_q;
    idx_d       = idx_q;
    now_d       = now_q;
    home_d      = home_q;
    addr_d      = addr_q;
    rd_vld_d    = 1'b0;
    rd_idx_d    = rd_idx_q;
    cand_d      = cand_q;
    cand_idx_d  = cand_idx_q;
    cand_dist_d = cand_dist_q;
    cand_time_d = cand_time_q;
    res_entry_d = res_entry_q;
    res_stat_d  = res_stat_q;
    res_hit_d   = res_hit_q;
    res_fill_d  = res_fill_q;
    rsp_vld_d   = rsp_vld_q && !rsp_o.ready;
    rsp_entry_d = rsp_entry_q;
    rsp_stat_d  = rsp_stat_q;
    rsp_hit_d   = rsp_hit_q;
    rsp_fill_d  = rsp_fill_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = '0;
    hash_start  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          mode_d = mode_e'(req_i.mode);
          dev_d  = req_i.device;
          blk_d  = req_i.block_number;
          idx_d  = req_i.entry_index;
          now_d  = req_i.now_tick;
          if (mode_e'(req_i.mode) == MODE_GET) begin
            hash_start = 1'b1;
            state_d    = S_HASH;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = ENT_W'(req_i.entry_index);
            state_d   = S_OPRD;
          end
        end
      end

      S_HASH: begin
        if (hash_rsp.done) begin
          home_d  = hash_rsp.home;
          addr_d  = '0;
          cand_d  = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read while the previous one is evaluated
        if (addr_q < (ENT_W + 1)'(NUM_ENTRIES)) begin
          ram_re    = 1'b1;
          ram_raddr = addr_q[ENT_W-1:0];
          addr_d    = addr_q + 1'b1;
          rd_vld_d  = 1'b1;
          rd_idx_d  = addr_q[ENT_W-1:0];
        end
        if (rd_vld_q) begin
          if (scan_live && ram_rdata.home == home_q && ram_rdata.dev == dev_q &&
              ram_rdata.blk == blk_q) begin
            // Hit: bump the count and mark valid
            ram_we        = 1'b1;
            ram_waddr     = rd_idx_q;
            ram_wdata.vld = 1'b1;
            if (ram_rdata.cnt != RCNT_MAX) begin
              ram_wdata.cnt = ram_rdata.cnt + 1'b1;
            end
            res_entry_d = IDX_W'(rd_idx_q);
            res_stat_d  = STAT_OK;
            res_hit_d   = 1'b1;
            res_fill_d  = !ram_rdata.vld;
            rd_vld_d    = 1'b0;
            state_d     = S_DONE;
          end else begin
            // Track the free entry nearest the home bucket, then oldest
            if (scan_live && ram_rdata.cnt == '0) begin
              if (!cand_q || gap < cand_dist_q ||
                  (gap == cand_dist_q && ram_rdata.rtime < cand_time_q)) begin
                cand_d      = 1'b1;
                cand_idx_d  = rd_idx_q;
                cand_dist_d = gap;
                cand_time_d = ram_rdata.rtime;
              end
            end
            if (rd_idx_q == ENT_W'(NUM_ENTRIES - 1)) begin
              state_d = S_ALLOC;
            end
          end
        end
      end

      S_ALLOC: begin
        ram_wdata.dev   = dev_q;
        ram_wdata.blk   = blk_q;
        ram_wdata.home  = home_q;
        ram_wdata.cnt   = RCNT_W'(1);
        ram_wdata.vld   = 1'b1;
        ram_wdata.rtime = cand_time_q;
        res_hit_d       = 1'b0;
        state_d         = S_DONE;
        if (32'(used_q) < 32'(NUM_ENTRIES)) begin
          ram_we      = 1'b1;
          ram_waddr   = used_q[ENT_W-1:0];
          ram_wdata.rtime = '0;
          used_d      = used_q + 1'b1;
          res_entry_d = IDX_W'(used_q[ENT_W-1:0]);
          res_stat_d  = STAT_OK;
          res_fill_d  = 1'b1;
        end else if (cand_q) begin
          ram_we      = 1'b1;
          ram_waddr   = cand_idx_q;
          res_entry_d = IDX_W'(cand_idx_q);
          res_stat_d  = STAT_OK;
          res_fill_d  = 1'b1;
        end else begin
          res_entry_d = '0;
          res_stat_d  = STAT_NO_FREE;
          res_fill_d  = 1'b0;
        end
      end

      S_OPRD: begin
        ram_waddr   = ENT_W'(idx_q);
        res_entry_d = idx_q;
        res_hit_d   = 1'b0;
        res_fill_d  = 1'b0;
        res_stat_d  = STAT_OK;
        if (mode_q == MODE_PIN) begin
          if (live && ram_rdata.cnt != RCNT_MAX) begin
            ram_we        = 1'b1;
            ram_wdata.cnt = ram_rdata.cnt + 1'b1;
          end
        end else if (!live || ram_rdata.cnt == '0) begin
          res_stat_d = STAT_ZERO;
        end else begin
          ram_we        = 1'b1;
          ram_wdata.cnt = ram_rdata.cnt - 1'b1;
          if (mode_q == MODE_RELEASE && ram_rdata.cnt == RCNT_W'(1)) begin
            ram_wdata.rtime = now_q;
          end
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        // Hand the result to the output register once it is free
        if (!rsp_vld_q || rsp_o.ready) begin
          rsp_vld_d   = 1'b1;
          rsp_entry_d = res_entry_q;
          rsp_stat_d  = res_stat_q;
          rsp_hit_d   = res_hit_q;
          rsp_fill_d  = res_fill_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      rd_vld_q  <= 1'b0;
      rsp_vld_q <= 1'b0;
      cand_q    <= 1'b0;
      addr_q    <= '0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      rd_vld_q  <= rd_vld_d;
      rsp_vld_q <= rsp_vld_d;
      cand_q    <= cand_d;
      addr_q    <= addr_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    mode_q      <= mode_d;
    dev_q       <= dev_d;
    blk_q       <= blk_d;
    idx_q       <= idx_d;
    now_q       <= now_d;
    home_q      <= home_d;
    rd_idx_q    <= rd_idx_d;
    cand_idx_q  <= cand_idx_d;
    cand_dist_q <= cand_dist_d;
    cand_time_q <= cand_time_d;
    res_entry_q <= res_entry_d;
    res_stat_q  <= res_stat_d;
    res_hit_q   <= res_hit_d;
    res_fill_q  <= res_fill_d;
    rsp_entry_q <= rsp_entry_d;
    rsp_stat_q  <= rsp_stat_d;
    rsp_hit_q   <= rsp_hit_d;
    rsp_fill_q  <= rsp_fill_d;
  end

  assign rsp_o.valid        = rsp_vld_q;
  assign rsp_o.result_entry = rsp_entry_q;
  assign rsp_o.status       = rsp_stat_q;
  assign rsp_o.was_hit      = rsp_hit_q;
  assign rsp_o.needs_fill   = rsp_fill_q;

endmodule
`default_nettype wire

FILE: hdl/hbc_checker.sv
`default_nettype none
module hbc_checker import hbc_pkg::*; (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic [IDX_W-1:0] rsp_entry,
  input wire logic [1:0]       rsp_status,
  input wire logic             rsp_hit,
  input wire logic             rsp_fill
);

  // A hit is always a successful get
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_hit |-> rsp_status == STAT_OK)
    else $error("hit reported with error status");

  // No-free answer carries no entry and no flags
  a_nofree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status == STAT_NO_FREE |-> rsp_entry == '0 && !rsp_hit && !rsp_fill)
    else $error("no-free transaction with payload");

  // Fill is only asked with a successful status
  a_fill_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_fill |-> rsp_status == STAT_OK)
    else $error("fill requested with error status");

  // An accepted request is not followed by another acceptance next cycle
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> !req_ready)
    else $error("back-to-back request acceptance");

  // Stalled response holds
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_entry) && $stable(rsp_status))
    else $error("stalled response changed");

endmodule

bind hashed_block_buffer_cache_core hbc_checker u_hbc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid  (req_i.valid),
  .req_ready  (req_i.ready),
  .rsp_valid  (rsp_o.valid),
  .rsp_ready  (rsp_o.ready),
  .rsp_entry  (rsp_o.result_entry),
  .rsp_status (rsp_o.status),
  .rsp_hit    (rsp_o.was_hit),
  .rsp_fill   (rsp_o.needs_fill)
);
`default_nettype wire
